### sv/mee_pkg.sv
// ----------------------------------------------------------------------------
// mee_pkg
// Shared widths, defaults and request codes of the matrix encoding embedder.
// ----------------------------------------------------------------------------
package mee_pkg;

    // Fixed field widths
    localparam int VALUE_W  = 16;
    localparam int CODE_K_W = 4;

    // Defaults of the top-level parameters
    localparam int K_MAX_DEF         = 8;
    localparam int POSITION_BITS_DEF = 24;

    // Smallest code size
    localparam int K_MIN = 2;

    // Request codes
    localparam logic REQ_MESSAGE = 1'b0;
    localparam logic REQ_COEFF   = 1'b1;

endpackage

### sv/mee_req_if.sv
// ----------------------------------------------------------------------------
// mee_req_if
// Request channel: message chunk loads and coefficient transactions.
// ----------------------------------------------------------------------------
interface mee_req_if #(
    parameter int MSG_W = mee_pkg::K_MAX_DEF,
    parameter int POS_W = mee_pkg::POSITION_BITS_DEF
);
    import mee_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [MSG_W-1:0]          message_bits;
    logic signed [VALUE_W-1:0] coeff_value;
    logic [POS_W-1:0]          coeff_position;

    modport source (
        output valid, req_type, message_bits, coeff_value, coeff_position,
        input  ready
    );

    modport sink (
        input  valid, req_type, message_bits, coeff_value, coeff_position,
        output ready
    );
endinterface

### sv/mee_res_if.sv
// ----------------------------------------------------------------------------
// mee_res_if
// Result channel: one transaction per filled group.
// ----------------------------------------------------------------------------
interface mee_res_if #(
    parameter int POS_W = mee_pkg::POSITION_BITS_DEF
);
    import mee_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      changed;
    logic                      shrunk;
    logic [POS_W-1:0]          change_position;
    logic signed [VALUE_W-1:0] new_value;

    modport source (
        output valid, changed, shrunk, change_position, new_value,
        input  ready
    );

    modport sink (
        input  valid, changed, shrunk, change_position, new_value,
        output ready
    );
endinterface

### sv/mee_group_ram.sv
// ----------------------------------------------------------------------------
// mee_group_ram
// Group entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mee_group_ram #(
    parameter int ADDR_W = mee_pkg::K_MAX_DEF,
    parameter int DATA_W = mee_pkg::VALUE_W + mee_pkg::POSITION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = (1 << ADDR_W) - 1;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/mee_core.sv
// ----------------------------------------------------------------------------
// mee_core
// Group fill, syndrome tracking, change selection and shrinkage compaction.
// ----------------------------------------------------------------------------
module mee_core #(
    parameter int K_MAX         = mee_pkg::K_MAX_DEF,
    parameter int POSITION_BITS = mee_pkg::POSITION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [K_MAX-1:0]                  i_n,
    mee_req_if.sink                           i_req,
    input  logic                              i_res_free,
    output logic                              o_res_load,
    output logic                              o_res_changed,
    output logic                              o_res_shrunk,
    output logic [POSITION_BITS-1:0]          o_res_position,
    output logic signed [mee_pkg::VALUE_W-1:0] o_res_value,
    output logic                              o_ram_we,
    output logic [K_MAX-1:0]                  o_ram_waddr,
    output logic [mee_pkg::VALUE_W+POSITION_BITS-1:0] o_ram_wdata,
    output logic [K_MAX-1:0]                  o_ram_raddr,
    input  logic [mee_pkg::VALUE_W+POSITION_BITS-1:0] i_ram_rdata
);
    import mee_pkg::*;

    localparam int DW = VALUE_W + POSITION_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_SHIFT,
        ST_DRAIN
    } t_state;

    t_state                    r_state;
    logic [K_MAX-1:0]          r_count;
    logic [K_MAX-1:0]          r_syn;
    logic [K_MAX-1:0]          r_msg;
    logic [K_MAX-1:0]          r_idx;
    logic                      r_dzero;
    logic [K_MAX-1:0]          r_i;
    logic                      r_wr_pend;
    logic [K_MAX-1:0]          r_wr_addr;

    logic                      accept;
    logic                      coeff_write;
    logic [K_MAX-1:0]          n_syn;
    logic [K_MAX-1:0]          n_count;
    logic [K_MAX-1:0]          d;
    logic signed [VALUE_W-1:0] rd_value;
    logic [POSITION_BITS-1:0]  rd_pos;
    logic signed [VALUE_W-1:0] new_val;
    logic [K_MAX-1:0]          shift_src;

    // Accept only between groups and outside compaction
    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign coeff_write = accept && (i_req.req_type == REQ_COEFF) && (i_req.coeff_value != '0);

    // Append the coefficient: next syndrome, count and distance
    assign n_syn   = i_req.coeff_value[0] ? (r_syn ^ (r_count + 1'b1)) : r_syn;
    assign n_count = r_count + 1'b1;
    assign d       = (n_syn ^ r_msg) & i_n;

    // Selected entry moved one step toward zero
    assign rd_value = i_ram_rdata[DW-1 -: VALUE_W];
    assign rd_pos   = i_ram_rdata[POSITION_BITS-1:0];
    assign new_val  = rd_value[VALUE_W-1] ? VALUE_W'(rd_value + 16'sd1)
                                          : VALUE_W'(rd_value - 16'sd1);

    // Compaction source: skip the removed entry
    assign shift_src = (r_i < r_idx) ? r_i : r_i + 1'b1;

    // Memory port steering
    always_comb begin
        o_ram_we    = coeff_write || r_wr_pend;
        o_ram_waddr = r_wr_pend ? r_wr_addr : r_count;
        o_ram_wdata = r_wr_pend ? i_ram_rdata : {i_req.coeff_value, i_req.coeff_position};
        o_ram_raddr = (r_state == ST_SHIFT) ? shift_src : r_idx;
    end

    // Result toward the output register
    always_comb begin
        o_res_load     = (r_state == ST_EVAL) && i_res_free;
        o_res_changed  = !r_dzero;
        o_res_shrunk   = !r_dzero && (new_val == '0);
        o_res_position = r_dzero ? '0 : rd_pos;
        o_res_value    = r_dzero ? '0 : new_val;
    end

    // State machine and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_syn     <= '0;
            r_msg     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_req.req_type == REQ_MESSAGE)) begin
                        r_msg <= i_req.message_bits;
                    end else if (coeff_write) begin
                        r_count <= n_count;
                        r_syn   <= n_syn;
                        if (n_count == i_n) begin
                            r_idx   <= d - 1'b1;
                            r_dzero <= (d == '0);
                            r_state <= ST_LOOKUP;
                        end
                    end
                end
                ST_LOOKUP: begin
                    r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (i_res_free) begin
                        r_syn <= '0;
                        if (!r_dzero && (new_val == '0)) begin
                            r_count <= i_n - 1'b1;
                            r_i     <= '0;
                            r_state <= ST_SHIFT;
                        end else begin
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SHIFT: begin
                    r_wr_pend <= 1'b1;
                    r_wr_addr <= r_i;
                    r_i       <= r_i + 1'b1;
                    if (r_i == r_count - 1'b1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Rebuild the syndrome as compacted entries are written back
            if (r_wr_pend && i_ram_rdata[POSITION_BITS]) begin
                r_syn <= r_syn ^ (r_wr_addr + 1'b1);
            end

            // Empty the group on a code size change
            if (i_cfg_we) begin
                r_count <= '0;
                r_syn   <= '0;
            end
        end
    end
endmodule

### sv/matrix_encoding_embedder_top.sv
// ----------------------------------------------------------------------------
// matrix_encoding_embedder_top
// Matrix encoding embedder: fills groups of 2^k-1 nonzero coefficients and
// reports the one coefficient change that embeds each k-bit message chunk.
// ----------------------------------------------------------------------------
//  channel   direction  handshake       payload
//  i_req     in         valid / ready   req_type, message_bits, coeff_value,
//                                       coeff_position
//  o_res     out        valid / ready   changed, shrunk, change_position,
//                                       new_value
//  i_cfg     in         write enable    code_k (4 bits)
//
//  A message load, a zero coefficient or a coefficient that does not fill the
//  group is taken in the idle state. The coefficient that fills the group
//  passes through append, store read and evaluate, plus any wait for the
//  output register. On shrinkage the group store is compacted through its
//  single read and write ports: n - 1 entries, then a drain step, n = 2^k - 1.
//  Reset is synchronous; the entry store needs no clearing pass.
//  A stalled result waits in the output register while input continues.
// ----------------------------------------------------------------------------
module matrix_encoding_embedder_top #(
    parameter int K_MAX         = mee_pkg::K_MAX_DEF,
    parameter int POSITION_BITS = mee_pkg::POSITION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mee_pkg::CODE_K_W-1:0]  i_cfg_wdata,
    mee_req_if.sink                       i_req,
    mee_res_if.source                     o_res
);
    import mee_pkg::*;

    localparam int              DW     = VALUE_W + POSITION_BITS;
    localparam int              KW1    = K_MAX + 1;
    localparam logic [4:0]      KMaxV  = 5'(K_MAX);
    localparam logic [4:0]      KMinV  = 5'(K_MIN);

    logic [K_MAX-1:0]          r_n;
    logic                      r_res_valid;
    logic                      r_res_changed;
    logic                      r_res_shrunk;
    logic [POSITION_BITS-1:0]  r_res_position;
    logic signed [VALUE_W-1:0] r_res_value;

    logic [4:0]                k_eff;
    logic [KW1-1:0]            n_full;
    logic                      res_free;
    logic                      res_load;
    logic                      res_changed;
    logic                      res_shrunk;
    logic [POSITION_BITS-1:0]  res_position;
    logic signed [VALUE_W-1:0] res_value;
    logic                      ram_we;
    logic [K_MAX-1:0]          ram_waddr;
    logic [DW-1:0]             ram_wdata;
    logic [K_MAX-1:0]          ram_raddr;
    logic [DW-1:0]             ram_rdata;

    // Saturate code size and derive group size
    always_comb begin
        k_eff = {1'b0, i_cfg_wdata};
        if (k_eff < KMinV) begin
            k_eff = KMinV;
        end
        if (k_eff > KMaxV) begin
            k_eff = KMaxV;
        end
        n_full = (KW1'(1) << k_eff) - KW1'(1);
    end

    // Hold group size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= K_MAX'((1 << K_MIN) - 1);
        end else if (i_cfg_we) begin
            r_n <= n_full[K_MAX-1:0];
        end
    end

    // Output register
    assign res_free = !r_res_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_load) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_res_changed  <= res_changed;
            r_res_shrunk   <= res_shrunk;
            r_res_position <= res_position;
            r_res_value    <= res_value;
        end
    end

    assign o_res.valid           = r_res_valid;
    assign o_res.changed         = r_res_changed;
    assign o_res.shrunk          = r_res_shrunk;
    assign o_res.change_position = r_res_position;
    assign o_res.new_value       = r_res_value;

    mee_core #(
        .K_MAX         (K_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_n            (r_n),
        .i_req          (i_req),
        .i_res_free     (res_free),
        .o_res_load     (res_load),
        .o_res_changed  (res_changed),
        .o_res_shrunk   (res_shrunk),
        .o_res_position (res_position),
        .o_res_value    (res_value),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata)
    );

    mee_group_ram #(
        .ADDR_W (K_MAX),
        .DATA_W (DW)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );
endmodule
